/* rtl/code128_symbol_encoder_macros.svh */
// Assertion helpers shared by the queue and emitter RTL modules.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef CODE128_SYMBOL_ENCODER_MACROS_SVH
`define CODE128_SYMBOL_ENCODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define C128_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define C128_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/c128_pkg.sv */
package c128_pkg;

  localparam logic [6:0]  MAX_CODE        = 7'd105;
  localparam logic [6:0]  START_FIRST     = 7'd103;
  localparam logic [6:0]  CHECK_MOD       = 7'd103;
  localparam logic [6:0]  WEIGHT_LAST     = 7'd102;
  // ceil(2^20 / 103); exact quotient for every dividend below 15650, which covers the
  // largest weighted product 102 * 127.
  localparam logic [13:0] RECIP_K         = 14'd10181;
  localparam int unsigned RECIP_SHIFT     = 20;
  localparam logic [3:0]  QZ_RESET        = 4'd10;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;
  // Stop pattern, one module width per hex digit, first element in the top digit.
  localparam logic [27:0] STOP_PAT        = 28'h2331112;

  typedef struct packed {
    logic [6:0] code_value;
    logic       last_symbol;
  } c128_in_t;

  typedef struct packed {
    logic [3:0] element_width;
    logic       is_bar;
    logic       run_last;
    logic       error;
  } c128_out_t;

  // One classified symbol word handed from the front end to the emitter.
  typedef struct packed {
    logic       err;
    logic       first;
    logic       last;
    logic [6:0] sym;
    logic [6:0] chk;
  } c128_entry_t;

  // Symbol patterns, six element widths per entry, one per hex digit.
  localparam logic [23:0] SYM_PAT [0:105] = '{
    24'h212222, 24'h222122, 24'h222221, 24'h121223, 24'h121322, 24'h131222, 24'h122213,
    24'h122312, 24'h132212, 24'h221213, 24'h221312, 24'h231212, 24'h112232, 24'h122132,
    24'h122231, 24'h113222, 24'h123122, 24'h123221, 24'h223211, 24'h221132, 24'h221231,
    24'h213212, 24'h223112, 24'h312131, 24'h311222, 24'h321122, 24'h321221, 24'h312212,
    24'h322112, 24'h322211, 24'h212123, 24'h212321, 24'h232121, 24'h111323, 24'h131123,
    24'h131321, 24'h112313, 24'h132113, 24'h132311, 24'h211313, 24'h231113, 24'h231311,
    24'h112133, 24'h112331, 24'h132131, 24'h113123, 24'h113321, 24'h133121, 24'h313121,
    24'h211331, 24'h231131, 24'h213113, 24'h213311, 24'h213131, 24'h311123, 24'h311321,
    24'h331121, 24'h312113, 24'h312311, 24'h332111, 24'h314111, 24'h221411, 24'h431111,
    24'h111224, 24'h111422, 24'h121124, 24'h121421, 24'h141122, 24'h141221, 24'h112214,
    24'h112412, 24'h122114, 24'h122411, 24'h142112, 24'h142211, 24'h241211, 24'h221114,
    24'h413111, 24'h241112, 24'h134111, 24'h111242, 24'h121142, 24'h121241, 24'h114212,
    24'h124112, 24'h124211, 24'h411212, 24'h421112, 24'h421211, 24'h212141, 24'h214121,
    24'h412121, 24'h111143, 24'h111341, 24'h131141, 24'h114113, 24'h114311, 24'h411113,
    24'h411311, 24'h113141, 24'h114131, 24'h311141, 24'h411131, 24'h211412, 24'h211214,
    24'h211232
  };

  function automatic logic [23:0] sym_pattern(input logic [6:0] v);
    logic [23:0] pat;
    pat = '0;
    if (v <= MAX_CODE) begin
      pat = SYM_PAT[v];
    end
    return pat;
  endfunction

endpackage

/* rtl/c128_front.sv */
module c128_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  c128_pkg::c128_in_t      in_data,
  output logic                    push_valid,
  output c128_pkg::c128_entry_t   push_entry,
  input  logic                    queue_full
);
  import c128_pkg::*;

  logic        adv;
  logic        accept;
  logic [6:0]  code;
  logic        err0;
  logic        first0;
  logic [6:0]  w_use;
  logic [13:0] prod0;

  logic        open_r, open_nxt;
  logic [6:0]  weight_r, weight_nxt;
  logic [6:0]  acc_r, acc_nxt;

  logic        s1_v_r, s2_v_r, s3_v_r;
  c128_entry_t s1_e_r, s2_e_r, s3_e_r;
  logic [13:0] s1_prod_r, s2_prod_r;
  logic [6:0]  s2_quot_r;
  logic [6:0]  s3_rem_r;

  logic [27:0] scaled;
  logic [13:0] rem;
  logic [6:0]  base;
  logic [7:0]  sum;
  logic [6:0]  chk;

  // The pipeline moves as a whole unless the last stage is blocked by a full queue.
  assign adv      = !s3_v_r || !queue_full;
  assign in_stall = !adv;
  assign accept   = in_valid && adv;

  // Classification and weight selection for the incoming word.
  assign code   = in_data.code_value;
  assign err0   = (code > MAX_CODE) || (!open_r && (code < START_FIRST));
  assign first0 = !open_r && !err0;
  assign w_use  = first0 ? 7'd1 : weight_r;
  assign prod0  = 14'(w_use) * 14'(code);

  always_comb begin
    open_nxt   = open_r;
    weight_nxt = weight_r;
    if (accept) begin
      if (err0 || in_data.last_symbol) begin
        open_nxt   = 1'b0;
        weight_nxt = '0;
      end else if (first0) begin
        open_nxt   = 1'b1;
        weight_nxt = 7'd1;
      end else begin
        weight_nxt = (weight_r == WEIGHT_LAST) ? 7'd0 : 7'(weight_r + 7'd1);
      end
    end
  end

  // Reduction of the weighted product modulo 103 by a reciprocal multiply.
  assign scaled = 28'(s1_prod_r) * 28'(RECIP_K);
  assign rem    = s2_prod_r - 14'(s2_quot_r) * 14'(CHECK_MOD);

  // Checksum accumulation; the first symbol starts a fresh sum.
  assign base = s3_e_r.first ? 7'd0 : acc_r;
  assign sum  = 8'(base) + 8'(s3_rem_r);
  assign chk  = (sum >= 8'(CHECK_MOD)) ? 7'(sum - 8'(CHECK_MOD)) : sum[6:0];

  always_comb begin
    acc_nxt = acc_r;
    if (push_valid && !s3_e_r.err) begin
      acc_nxt = chk;
    end
  end

  assign push_valid = s3_v_r && !queue_full;

  always_comb begin
    push_entry     = s3_e_r;
    push_entry.chk = chk;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r   <= 1'b0;
      weight_r <= '0;
      acc_r    <= '0;
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      s3_v_r   <= 1'b0;
    end else begin
      open_r   <= open_nxt;
      weight_r <= weight_nxt;
      acc_r    <= acc_nxt;
      if (adv) begin
        s1_v_r <= accept;
        s2_v_r <= s1_v_r;
        s3_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_e_r.err   <= err0;
      s1_e_r.first <= first0;
      s1_e_r.last  <= in_data.last_symbol;
      s1_e_r.sym   <= code;
      s1_e_r.chk   <= '0;
      s1_prod_r    <= prod0;
      s2_e_r       <= s1_e_r;
      s2_prod_r    <= s1_prod_r;
      s2_quot_r    <= scaled[RECIP_SHIFT + 6:RECIP_SHIFT];
      s3_e_r       <= s2_e_r;
      s3_rem_r     <= rem[6:0];
    end
  end

endmodule

/* rtl/c128_fifo.sv */
`include "code128_symbol_encoder_macros.svh"

module c128_fifo #(
  parameter int unsigned DEPTH = c128_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push_valid,
  input  c128_pkg::c128_entry_t push_entry,
  output logic                  full,
  input  logic                  pop,
  output c128_pkg::c128_entry_t pop_entry,
  output logic                  empty
);
  import c128_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  c128_entry_t      slots [0:DEPTH-1];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign empty     = (count_r == '0);
  assign pop_entry = slots[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_valid) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_r + 1'b1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_r + 1'b1);
    end
    if (push_valid && !pop) begin
      count_nxt = CNT_W'(count_r + 1'b1);
    end else if (pop && !push_valid) begin
      count_nxt = CNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid) begin
      slots[wr_ptr_r] <= push_entry;
    end
  end

  `C128_ASSERT_SAME(a_no_overflow, push_valid, !full, "queue written while full")
  `C128_ASSERT_SAME(a_no_underflow, pop, !empty, "queue read while empty")
  `C128_ASSERT_SAME(a_count_range, 1'b1, count_r <= CNT_W'(DEPTH), "queue count past depth")

endmodule

/* rtl/c128_back.sv */
`include "code128_symbol_encoder_macros.svh"

module c128_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  c128_pkg::c128_entry_t q_entry,
  output logic                  q_pop,
  input  logic [3:0]            qz_width,
  output logic                  out_valid,
  input  logic                  out_stall,
  output c128_pkg::c128_out_t   out_data
);
  import c128_pkg::*;

  localparam logic [2:0] PH_ERR   = 3'd0;
  localparam logic [2:0] PH_LEAD  = 3'd1;
  localparam logic [2:0] PH_SYM   = 3'd2;
  localparam logic [2:0] PH_CHK   = 3'd3;
  localparam logic [2:0] PH_STOP  = 3'd4;
  localparam logic [2:0] PH_TRAIL = 3'd5;

  logic        busy_r;
  logic [2:0]  phase_r, phase_nxt;
  logic [2:0]  idx_r, idx_nxt;
  c128_entry_t cur_r;
  logic        out_valid_r;
  c128_out_t   out_data_r;

  logic        load_ok;
  logic        emit;
  logic        done;
  logic [6:0]  sel_sym;
  logic [23:0] pat;
  logic [3:0]  sym_digit;
  logic [3:0]  stop_digit;
  c128_out_t   elem;
  logic [2:0]  start_phase;

  assign load_ok = !out_valid_r || !out_stall;
  assign emit    = busy_r && load_ok;

  assign sel_sym = (phase_r == PH_CHK) ? cur_r.chk : cur_r.sym;
  assign pat     = sym_pattern(sel_sym);

  always_comb begin
    case (idx_r)
      3'd0:    sym_digit = pat[23:20];
      3'd1:    sym_digit = pat[19:16];
      3'd2:    sym_digit = pat[15:12];
      3'd3:    sym_digit = pat[11:8];
      3'd4:    sym_digit = pat[7:4];
      3'd5:    sym_digit = pat[3:0];
      default: sym_digit = '0;
    endcase
  end

  always_comb begin
    case (idx_r)
      3'd0:    stop_digit = STOP_PAT[27:24];
      3'd1:    stop_digit = STOP_PAT[23:20];
      3'd2:    stop_digit = STOP_PAT[19:16];
      3'd3:    stop_digit = STOP_PAT[15:12];
      3'd4:    stop_digit = STOP_PAT[11:8];
      3'd5:    stop_digit = STOP_PAT[7:4];
      3'd6:    stop_digit = STOP_PAT[3:0];
      default: stop_digit = '0;
    endcase
  end

  // Element generation and sequencing through the parts of one word.
  always_comb begin
    elem      = '0;
    done      = 1'b0;
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    case (phase_r)
      PH_ERR: begin
        elem.error = 1'b1;
        done       = 1'b1;
      end
      PH_LEAD: begin
        elem.element_width = qz_width;
        phase_nxt          = PH_SYM;
        idx_nxt            = '0;
      end
      PH_SYM: begin
        elem.element_width = sym_digit;
        elem.is_bar        = !idx_r[0];
        if (idx_r == 3'd5) begin
          done      = !cur_r.last;
          phase_nxt = PH_CHK;
          idx_nxt   = '0;
        end else begin
          idx_nxt = 3'(idx_r + 3'd1);
        end
      end
      PH_CHK: begin
        elem.element_width = sym_digit;
        elem.is_bar        = !idx_r[0];
        if (idx_r == 3'd5) begin
          phase_nxt = PH_STOP;
          idx_nxt   = '0;
        end else begin
          idx_nxt = 3'(idx_r + 3'd1);
        end
      end
      PH_STOP: begin
        elem.element_width = stop_digit;
        elem.is_bar        = !idx_r[0];
        if (idx_r == 3'd6) begin
          phase_nxt = PH_TRAIL;
          idx_nxt   = '0;
        end else begin
          idx_nxt = 3'(idx_r + 3'd1);
        end
      end
      PH_TRAIL: begin
        elem.element_width = qz_width;
        done               = 1'b1;
      end
      default: begin
        done = 1'b1;
      end
    endcase
    elem.run_last = done;
  end

  always_comb begin
    if (q_entry.err) begin
      start_phase = PH_ERR;
    end else if (q_entry.first) begin
      start_phase = PH_LEAD;
    end else begin
      start_phase = PH_SYM;
    end
  end

  // A new word is taken as soon as the current one hands over its final element.
  assign q_pop = !q_empty && (!busy_r || (emit && done));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      phase_r     <= PH_ERR;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        busy_r  <= 1'b1;
        phase_r <= start_phase;
        idx_r   <= '0;
      end else if (emit && done) begin
        busy_r <= 1'b0;
      end else if (emit) begin
        phase_r <= phase_nxt;
        idx_r   <= idx_nxt;
      end
      if (load_ok) begin
        out_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_entry;
    end
    if (emit) begin
      out_data_r <= elem;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `C128_ASSERT_SAME(a_sym_idx,
    busy_r && (phase_r == PH_SYM || phase_r == PH_CHK),
    idx_r <= 3'd5, "symbol element index past six")
  `C128_ASSERT_SAME(a_err_word, out_valid_r && out_data_r.error,
    out_data_r.run_last && (out_data_r.element_width == 4'd0) && !out_data_r.is_bar,
    "malformed error word")
  `C128_ASSERT_NEXT(a_pop_busy, q_pop, busy_r, "emitter idle after taking a word")

endmodule

/* rtl/code128_symbol_encoder.sv */
// Code 128 symbol encoder. Each input word carries one symbol value (0 to 105) and a
// last-symbol flag; the block answers with one output word per bar or space, giving its
// width in modules, whether it is a bar, and a run_last flag on the final word caused by
// that input. A barcode must open with a start code (103 to 105), which is preceded by
// a quiet-zone space; the flagged last symbol is followed by the mod-103 checksum
// symbol, the seven-element stop pattern and a trailing quiet zone. A value above 105,
// or a barcode that does not open with a start code, yields a single error word and
// drops the barcode. Rate: the output side emits one element per cycle unless out_stall
// holds it, so an ordinary symbol gives 6 elements, an opening symbol 7, and a last
// symbol 14 more (checksum, stop and quiet zone); the element emitter sets this rate.
// The front end accepts one word per cycle as long as the symbol queue has room, and
// each word passes the stage registers s1, s2 and s3 before it reaches the queue.
module code128_symbol_encoder #(
  parameter int unsigned QUEUE_DEPTH = c128_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  c128_pkg::c128_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output c128_pkg::c128_out_t out_data,
  input  logic                cfg_wr_en,
  input  logic [3:0]          cfg_wr_data
);
  import c128_pkg::*;

  // Quiet-zone width register; it is read when the quiet-zone elements are emitted.
  logic [3:0]  qz_width_r;

  logic        push_valid;
  c128_entry_t push_entry;
  logic        queue_full;
  logic        queue_empty;
  logic        queue_pop;
  c128_entry_t queue_entry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qz_width_r <= QZ_RESET;
    end else if (cfg_wr_en) begin
      qz_width_r <= cfg_wr_data;
    end
  end

  // The front end classifies each word, tracks the barcode state and folds the
  // symbol into the weighted checksum.
  c128_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .queue_full (queue_full)
  );

  // The queue lets the front end run ahead while the emitter serializes elements.
  c128_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (queue_pop),
    .pop_entry  (queue_entry),
    .empty      (queue_empty)
  );

  // The emitter walks through quiet zone, symbol, checksum and stop elements, or gives
  // a single error word, and drives the registered output.
  c128_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (queue_empty),
    .q_entry   (queue_entry),
    .q_pop     (queue_pop),
    .qz_width  (qz_width_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
